/* design/lkrs_pkg.sv */
package lkrs_pkg;

  localparam int unsigned MAX_LEN       = 4096;
  localparam int unsigned TABLE_ENTRIES = 8192;
  localparam int unsigned HASH_W        = 30;
  localparam int unsigned LEN_W         = $clog2(MAX_LEN + 1);
  localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = 13;
  localparam int unsigned STEP_W        = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] HASH_BASE = HASH_W'(31);
  localparam logic [HASH_W:0]   HASH_MOD  = (HASH_W + 1)'(1000000007);

  // operand request and response of the modular multiplier
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] result;
  } mm_rsp_t;

endpackage

/* design/lkrs_modmul.sv */
// Serial modular multiplier: one bit of b per cycle, most significant first.
module lkrs_modmul
  import lkrs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  mm_req_t req_i,
  output mm_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [HASH_W-1:0] a_q, a_d;
  logic [HASH_W-1:0] b_q, b_d;
  logic [HASH_W-1:0] r_q, r_d;
  logic [HASH_W:0]   dbl, dbl_red, acc, acc_red;

  always_comb begin
    // double, reduce, then add a if the current bit of b is set and reduce again
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= HASH_MOD) ? dbl - HASH_MOD : dbl;
    acc     = b_q[HASH_W-1] ? dbl_red + {1'b0, a_q} : dbl_red;
    acc_red = (acc >= HASH_MOD) ? acc - HASH_MOD : acc;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    a_d    = a_q;
    b_d    = b_q;
    r_d    = r_q;
    if (busy_q) begin
      r_d = acc_red[HASH_W-1:0];
      b_d = {b_q[HASH_W-2:0], 1'b0};
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(HASH_W - 1);
      a_d    = req_i.a;
      b_d    = req_i.b;
      r_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    r_q <= r_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = r_q;

endmodule

/* design/longest_k_repeated_substring_core.sv */
// Longest substring that repeats at least min_repeats times, by rolling hash.
//
// Requests: drive letter_i/last_i with start high while busy is low; one
// letter is taken per request. Each stored letter takes two passes through
// the bit-serial modular multiplier (power and prefix hash).
// The request with last_i high starts a binary search over the window length.
// Each tried length first clears the 8192-entry count table, one entry a
// cycle, then visits the windows in order until one reaches min_repeats
// or the last is done: two hash-memory reads, one multiply and one or more
// probes of the count table a window. The search runs for up to log2(n)+1
// lengths; busy stays high throughout and start is ignored.
// The answer appears on longest_length_o for one cycle with result_valid_o
// high, after which the next request begins a new string. The receiver
// cannot stall; take the result in that cycle.
// Reset empties the string, sets min_repeats to 2 and leaves the memories
// uninitialised; the count table is swept before each length, so no pass
// is needed after reset. Letters beyond MAX_LEN are dropped.
// cfg_we_i/cfg_wdata_i write min_repeats; write only while idle.
module longest_k_repeated_substring_core
  import lkrs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [4:0]       letter_i,
  input  logic             last_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic             result_valid_o,
  output logic [LEN_W-1:0] longest_length_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LPW   = 4'd1;
  localparam logic [3:0] ST_LPH   = 4'd2;
  localparam logic [3:0] ST_SINIT = 4'd3;
  localparam logic [3:0] ST_SMID  = 4'd4;
  localparam logic [3:0] ST_CLR   = 4'd5;
  localparam logic [3:0] ST_PWR   = 4'd6;
  localparam logic [3:0] ST_RDA   = 4'd7;
  localparam logic [3:0] ST_RDB   = 4'd8;
  localparam logic [3:0] ST_RDC   = 4'd9;
  localparam logic [3:0] ST_MUL   = 4'd10;
  localparam logic [3:0] ST_PROBE = 4'd11;
  localparam logic [3:0] ST_CHK   = 4'd12;

  localparam int unsigned HWORD_W = 2 * HASH_W;
  localparam int unsigned CWORD_W = 1 + HASH_W + CNT_W;

  // hash memory word: power in the upper half, prefix hash in the lower
  logic [HWORD_W-1:0] hash_mem [MAX_LEN+1];
  logic [HWORD_W-1:0] hash_rd_q;
  logic               hash_zero_q;
  logic               hash_we;
  logic [LEN_W-1:0]   hash_waddr, hash_raddr;
  logic [HWORD_W-1:0] hash_wdata, hash_word;

  // count table word: valid, key, count
  logic [CWORD_W-1:0] cnt_mem [TABLE_ENTRIES];
  logic [CWORD_W-1:0] cnt_rd_q;
  logic               cnt_we;
  logic [SLOT_W-1:0]  cnt_waddr, cnt_raddr;
  logic [CWORD_W-1:0] cnt_wdata;

  logic [3:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_cnt_q, len_cnt_d;
  logic [HASH_W-1:0] pw_q, pw_d, ph_q, ph_d;
  logic [4:0]        code_q, code_d;
  logic              last_q, last_d;
  logic [LEN_W-1:0]  low_q, low_d, high_q, high_d, best_q, best_d, mid_q, mid_d;
  logic [LEN_W-1:0]  base_q, base_d, tidx_q, tidx_d;
  logic [HASH_W-1:0] pwlen_q, pwlen_d, head_q, head_d, tail_q, tail_d;
  logic [HASH_W-1:0] key_q, key_d;
  logic [SLOT_W-1:0] slot_q, slot_d, clr_q, clr_d;
  logic [CNT_W-1:0]  min_rep_q;
  logic              res_vld_q, res_vld_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic [LEN_W:0]    mid_sum;
  logic [HASH_W:0]   ph_sum, diff;
  logic              ent_vld;
  logic [HASH_W-1:0] ent_key;
  logic [CNT_W-1:0]  ent_cnt, new_cnt;

  lkrs_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // entry zero is fixed: power 1, prefix hash 0
  assign hash_word = hash_zero_q ? {HASH_W'(1), HASH_W'(0)} : hash_rd_q;
  assign ent_vld   = cnt_rd_q[CWORD_W-1];
  assign ent_key   = cnt_rd_q[CNT_W +: HASH_W];
  assign ent_cnt   = cnt_rd_q[CNT_W-1:0];
  assign busy      = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    len_cnt_d = len_cnt_q;
    pw_d      = pw_q;
    ph_d      = ph_q;
    code_d    = code_q;
    last_d    = last_q;
    low_d     = low_q;
    high_d    = high_q;
    best_d    = best_q;
    mid_d     = mid_q;
    base_d    = base_q;
    tidx_d    = tidx_q;
    pwlen_d   = pwlen_q;
    head_d    = head_q;
    tail_d    = tail_q;
    key_d     = key_q;
    slot_d    = slot_q;
    clr_d     = clr_q;
    res_vld_d = 1'b0;
    res_len_d = res_len_q;

    mm_req     = '0;
    hash_we    = 1'b0;
    hash_waddr = len_cnt_q + LEN_W'(1);
    hash_wdata = '0;
    hash_raddr = base_q;
    cnt_we     = 1'b0;
    cnt_waddr  = slot_q;
    cnt_wdata  = '0;
    cnt_raddr  = slot_q;

    mid_sum = {1'b0, low_q} + {1'b0, high_q};
    ph_sum  = {1'b0, mm_rsp.result} + (HASH_W + 1)'(code_q) + (HASH_W + 1)'(1);
    diff    = (tail_q >= mm_rsp.result) ? {1'b0, tail_q} - {1'b0, mm_rsp.result}
                                        : {1'b0, tail_q} + HASH_MOD - {1'b0, mm_rsp.result};
    new_cnt = (ent_cnt == '1) ? ent_cnt : ent_cnt + CNT_W'(1);

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          code_d = letter_i;
          last_d = last_i;
          if (len_cnt_q < LEN_W'(MAX_LEN)) begin
            mm_req.start = 1'b1;
            mm_req.a     = pw_q;
            mm_req.b     = HASH_BASE;
            state_d      = ST_LPW;
          end else if (last_i) begin
            state_d = ST_SINIT;
          end
        end
      end
      ST_LPW: begin
        if (mm_rsp.done) begin
          pw_d         = mm_rsp.result;
          mm_req.start = 1'b1;
          mm_req.a     = ph_q;
          mm_req.b     = HASH_BASE;
          state_d      = ST_LPH;
        end
      end
      ST_LPH: begin
        if (mm_rsp.done) begin
          // add the letter value plus one and fold back below the modulus
          if (ph_sum >= HASH_MOD) ph_d = HASH_W'(ph_sum - HASH_MOD);
          else                    ph_d = ph_sum[HASH_W-1:0];
          hash_we    = 1'b1;
          hash_wdata = {pw_q, ph_d};
          len_cnt_d  = len_cnt_q + LEN_W'(1);
          state_d    = last_q ? ST_SINIT : ST_IDLE;
        end
      end
      ST_SINIT: begin
        low_d   = LEN_W'(1);
        high_d  = len_cnt_q;
        best_d  = '0;
        state_d = ST_SMID;
      end
      ST_SMID: begin
        if (low_q > high_q) begin
          // search done: emit and start a fresh string
          res_vld_d = 1'b1;
          res_len_d = best_q;
          len_cnt_d = '0;
          pw_d      = HASH_W'(1);
          ph_d      = '0;
          state_d   = ST_IDLE;
        end else begin
          mid_d   = mid_sum[LEN_W:1];
          clr_d   = '0;
          state_d = ST_CLR;
        end
      end
      ST_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_q;
        clr_d     = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(TABLE_ENTRIES - 1)) begin
          hash_raddr = mid_q;
          state_d    = ST_PWR;
        end
      end
      ST_PWR: begin
        pwlen_d = hash_word[HWORD_W-1:HASH_W];
        base_d  = '0;
        tidx_d  = mid_q;
        state_d = ST_RDA;
      end
      ST_RDA: begin
        hash_raddr = base_q;
        state_d    = ST_RDB;
      end
      ST_RDB: begin
        head_d     = hash_word[HASH_W-1:0];
        hash_raddr = tidx_q;
        state_d    = ST_RDC;
      end
      ST_RDC: begin
        tail_d       = hash_word[HASH_W-1:0];
        mm_req.start = 1'b1;
        mm_req.a     = head_q;
        mm_req.b     = pwlen_q;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        if (mm_rsp.done) begin
          key_d   = diff[HASH_W-1:0];
          slot_d  = diff[SLOT_W-1:0];
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        cnt_raddr = slot_q;
        state_d   = ST_CHK;
      end
      ST_CHK: begin
        // the table holds twice the longest string, so a probe always ends
        if (ent_vld && ent_key != key_q) begin
          slot_d  = slot_q + SLOT_W'(1);
          state_d = ST_PROBE;
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = slot_q;
          if (!ent_vld) new_cnt = CNT_W'(1);
          cnt_wdata = {1'b1, key_q, new_cnt};
          if (new_cnt >= min_rep_q) begin
            if (mid_q > best_q) best_d = mid_q;
            low_d   = mid_q + LEN_W'(1);
            state_d = ST_SMID;
          end else if (tidx_q == len_cnt_q) begin
            high_d  = mid_q - LEN_W'(1);
            state_d = ST_SMID;
          end else begin
            base_d  = base_q + LEN_W'(1);
            tidx_d  = tidx_q + LEN_W'(1);
            state_d = ST_RDA;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_cnt_q <= '0;
      pw_q      <= HASH_W'(1);
      ph_q      <= '0;
      low_q     <= LEN_W'(1);
      high_q    <= '0;
      best_q    <= '0;
      min_rep_q <= CNT_W'(2);
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_cnt_q <= len_cnt_d;
      pw_q      <= pw_d;
      ph_q      <= ph_d;
      low_q     <= low_d;
      high_q    <= high_d;
      best_q    <= best_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) min_rep_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    last_q    <= last_d;
    mid_q     <= mid_d;
    base_q    <= base_d;
    tidx_q    <= tidx_d;
    pwlen_q   <= pwlen_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
    key_q     <= key_d;
    slot_q    <= slot_d;
    clr_q     <= clr_d;
    res_len_q <= res_len_d;
  end

  always_ff @(posedge clk_i) begin
    if (hash_we) hash_mem[hash_waddr] <= hash_wdata;
    hash_rd_q   <= hash_mem[hash_raddr];
    hash_zero_q <= (hash_raddr == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  assign result_valid_o   = res_vld_q;
  assign longest_length_o = res_len_q;

endmodule

/* design/lkrs_checker.sv */
module lkrs_checker
  import lkrs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input logic [LEN_W-1:0] longest_length_o
);

  // a result is a single-cycle strobe
  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // a result only follows the end of a search
  a_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy && $past(busy))
    else $error("result without a preceding search");

  // an accepted request never yields a result in the next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result straight after a request");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> longest_length_o <= LEN_W'(MAX_LEN))
    else $error("length beyond the string limit");

endmodule

bind longest_k_repeated_substring_core lkrs_checker u_lkrs_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .result_valid_o   (result_valid_o),
  .longest_length_o (longest_length_o)
);
